@@ design/swwt_pkg.sv @@
// Package for the signal wait and wake table.
// Holds table sizing, field widths, codes, the entry record and the
// command and status structs that join the controller and the datapath.
package swwt_pkg;

    // Table sizing.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths.
    localparam int THREAD_W = 8;
    localparam int TYPE_W   = 8;
    localparam int ADDR_W   = 32;
    localparam int TICK_W   = 32;
    localparam int IN_DW    = THREAD_W + TYPE_W + ADDR_W + TICK_W;
    localparam int OUT_DW   = THREAD_W + TYPE_W + ADDR_W;

    // Special values.
    localparam logic [TICK_W-1:0] FOREVER      = '1;
    localparam logic [TYPE_W-1:0] TIMEOUT_CODE = 8'hFF;

    // Item kinds; the fourth code is unused: an item with it is accepted and only captures its payload.
    typedef enum logic [1:0] {
        KIND_WAIT  = 2'd0,
        KIND_RAISE = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_MATCH   = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_WAIT_OK = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_FINISH
    } t_state;

    // One table entry.
    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic [TYPE_W-1:0]   stype;
        logic [ADDR_W-1:0]   addr;
        logic [TICK_W-1:0]   start;
        logic [TICK_W-1:0]   limit;
    } t_entry;

    // One result waiting to be sent.
    typedef struct packed {
        t_status             status;
        logic [THREAD_W-1:0] thread;
        logic [TYPE_W-1:0]   stype;
        logic [ADDR_W-1:0]   addr;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the input payload
        logic tick;       // advance the tick counter
        logic scan_start; // read entry zero, reset scan pointers
        logic step;       // process the entry in the read register
        logic raise;      // current scan compares type and address
        logic append;     // store a new entry or report the table full
        logic flush;      // send the held result as the final one
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic woken;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

endpackage

@@ design/swwt_ctrl.sv @@
// Controller state machine for the signal wait and wake table.
// Depends on swwt_pkg; drives the datapath only through t_dp_cmd.
module swwt_ctrl
    import swwt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // kind
    input  t_dp_stat    i_stat,
    output t_dp_cmd     o_cmd
);

    t_state r_state, n_state;
    logic   r_raise, n_raise;

    // State and scan mode registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_raise <= 1'b0;
        end else begin
            r_state <= n_state;
            r_raise <= n_raise;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        n_raise       = r_raise;
        s_axis_tready = 1'b0;
        o_cmd         = '0;
        o_cmd.raise   = r_raise;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.latch = 1'b1;
                    unique case (s_axis_tuser)
                        KIND_WAIT: begin
                            n_state = S_APPEND;
                        end
                        KIND_RAISE: begin
                            n_raise = 1'b1;
                            if (!i_stat.count_zero) begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = S_SCAN;
                            end
                        end
                        KIND_TICK: begin
                            n_raise    = 1'b0;
                            o_cmd.tick = 1'b1;
                            if (!i_stat.count_zero) begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_FINISH;
            end
            S_SCAN: begin
                // A wake must first move the held result out, which needs room.
                if (!(i_stat.woken && i_stat.pend_valid && !i_stat.out_free)) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.scan_last) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/swwt_dp.sv @@
// Datapath for the signal wait and wake table: entry memory, scan
// pointers, tick counter, held result and output register. Uses swwt_pkg.
module swwt_dp
    import swwt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // thread_id, signal_type, signal_addr, wait_timeout
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // woken_thread, wake_type, wake_addr
    output logic [1:0]        m_axis_tuser,   // status
    output logic              m_axis_tlast,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat
);

    // Captured input payload.
    logic [THREAD_W-1:0] r_thread;
    logic [TYPE_W-1:0]   r_type;
    logic [ADDR_W-1:0]   r_addr;
    logic [TICK_W-1:0]   r_timeout;

    // Time, fill count and scan pointers.
    logic [TICK_W-1:0]   r_now;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_keep, n_keep;

    // Entry memory and its read register.
    t_entry              mem [TABLE_DEPTH];
    t_entry              r_rd;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              wr_data;

    // Held result and output register.
    logic                r_pend_valid;
    t_result             r_pend, n_pend;
    logic                r_out_valid;
    t_result             r_out;
    logic                r_out_last;

    logic                hit;
    logic                expired;
    logic                woken;
    logic [TICK_W:0]     deadline;
    logic                has_room;
    logic                push_mid;
    logic                push_last;
    logic                out_free;

    // Match and expiry checks on the entry being scanned.
    assign deadline = {1'b0, r_rd.start} + {1'b0, r_rd.limit};
    assign expired  = (r_rd.limit != FOREVER) && ({1'b0, r_now} >= deadline);
    assign hit      = i_cmd.raise && (r_rd.stype == r_type) && (r_rd.addr == r_addr);
    assign woken    = hit || expired;
    assign has_room = (r_count < CNT_W'(TABLE_DEPTH));
    assign out_free = !r_out_valid || m_axis_tready;

    assign push_mid  = i_cmd.step && woken && r_pend_valid;
    assign push_last = i_cmd.flush && r_pend_valid;

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.scan_last  = ((CNT_W'(r_idx) + 1'b1) == r_count);
    assign o_stat.woken      = woken;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;

    // Memory port selection.
    always_comb begin
        rd_en   = i_cmd.scan_start || (i_cmd.step && !o_stat.scan_last);
        rd_addr = i_cmd.scan_start ? '0 : IDX_W'(r_idx + 1'b1);
        wr_en   = (i_cmd.append && has_room) || (i_cmd.step && !woken);
        wr_addr = i_cmd.append ? r_count[IDX_W-1:0] : r_keep[IDX_W-1:0];
        wr_data = r_rd;
        if (i_cmd.append) begin
            wr_data.thread = r_thread;
            wr_data.stype  = r_type;
            wr_data.addr   = r_addr;
            wr_data.start  = r_now;
            wr_data.limit  = r_timeout;
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Input payload capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_thread  <= s_axis_tdata[THREAD_W-1:0];
            r_type    <= s_axis_tdata[THREAD_W +: TYPE_W];
            r_addr    <= s_axis_tdata[THREAD_W+TYPE_W +: ADDR_W];
            r_timeout <= s_axis_tdata[THREAD_W+TYPE_W+ADDR_W +: TICK_W];
        end
    end

    // Next fill count and keep pointer.
    always_comb begin
        n_count = r_count;
        n_keep  = r_keep;
        if (i_cmd.scan_start) begin
            n_keep = '0;
        end else if (i_cmd.step) begin
            if (!woken) begin
                n_keep = r_keep + 1'b1;
            end
            if (o_stat.scan_last) begin
                n_count = n_keep;
            end
        end else if (i_cmd.append && has_room) begin
            n_count = r_count + 1'b1;
        end
    end

    // Tick counter, fill count and scan pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_keep  <= '0;
        end else begin
            if (i_cmd.tick && (r_now != '1)) begin
                r_now <= r_now + 1'b1;
            end
            r_count <= n_count;
            r_keep  <= n_keep;
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= IDX_W'(r_idx + 1'b1);
            end
        end
    end

    // Result to hold back until the next one shows whether it is the last.
    always_comb begin
        n_pend = r_pend;
        if (i_cmd.append) begin
            n_pend.status = has_room ? ST_WAIT_OK : ST_FULL;
            n_pend.thread = r_thread;
            n_pend.stype  = r_type;
            n_pend.addr   = r_addr;
        end else if (i_cmd.step && woken) begin
            n_pend.status = hit ? ST_MATCH : ST_TIMEOUT;
            n_pend.thread = r_rd.thread;
            n_pend.stype  = hit ? r_type : TIMEOUT_CODE;
            n_pend.addr   = hit ? r_addr : '0;
        end
    end

    // Held result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.append || (i_cmd.step && woken)) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    // Output register: a held result moves out when a newer one arrives or at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_mid || push_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_mid || push_last) begin
            r_out      <= r_pend;
            r_out_last <= push_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.addr, r_out.stype, r_out.thread};
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ design/signal_wait_wake_table.sv @@
// Channel   Dir  Bits  Contents (lowest bit first)
// s_axis    in   80    tdata: thread_id, signal_type, signal_addr, wait_timeout
//                      tuser: kind
// m_axis    out  48    tdata: woken_thread, wake_type, wake_addr
//                      tuser: status; tlast: final result of the item
//
// A wait is accepted, then stored in the table (or reported full), then its result is handed off.
// A raise or tick scans the stored entries: the scan reads one entry per cycle, unless
// a wake waits for the output, through the read port of the table memory and writes
// survivors toward the front through its write port. On an empty table no scan is made.
// Reset (synchronous, active low) empties the table and clears the tick counter.
// A wake waits while a result is held and the output register still holds an unaccepted transaction.
// Top level of the signal wait and wake table; uses swwt_pkg, swwt_ctrl and swwt_dp.
module signal_wait_wake_table
    import swwt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // thread_id, signal_type, signal_addr, wait_timeout
    input  logic [1:0]        s_axis_tuser,   // kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // woken_thread, wake_type, wake_addr
    output logic [1:0]        m_axis_tuser,   // status
    output logic              m_axis_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer.
    swwt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    // Table, timer and result path.
    swwt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule
